>>> hw/rtl/slps_pkg.sv
// shared types and constants of the status led pattern selector
package slps_pkg;

  // led action codes as they leave the block
  typedef enum logic [2:0] {
    ACT_KEEP   = 3'd0,
    ACT_OFF    = 3'd1,
    ACT_RED    = 3'd2,
    ACT_GREEN  = 3'd3,
    ACT_BLUE   = 3'd4,
    ACT_YELLOW = 3'd5,
    ACT_WHITE  = 3'd6
  } act_e;

  // run status codes, codes above probe calibration act as other
  localparam logic [2:0] ST_OTHER     = 3'd0;
  localparam logic [2:0] ST_CONNECTED = 3'd1;
  localparam logic [2:0] ST_SELFTEST2 = 3'd2;
  localparam logic [2:0] ST_LOGGING   = 3'd3;
  localparam logic [2:0] ST_PROBECAL  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_LOW_BATT   = 2'd0;
  localparam logic [1:0] REG_ST_ROUNDS  = 2'd1;
  localparam logic [1:0] REG_PROBE_BAND = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // tick phase period and its last value
  localparam logic [4:0] PHASE_LAST = 5'd19;

  // phase marks of the self-test round
  localparam logic [4:0] PH_ST_RED   = 5'd0;
  localparam logic [4:0] PH_ST_GREEN = 5'd5;
  localparam logic [4:0] PH_ST_BLUE  = 5'd10;
  localparam logic [4:0] PH_ST_OFF   = 5'd15;

  // reset values of the registers
  localparam logic [7:0]        LOW_BATT_RST   = 8'd1;
  localparam logic [3:0]        ST_ROUNDS_RST  = 4'd3;
  localparam logic signed [15:0] PROBE_BAND_RST = 16'sd800;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 8;

  // one status tick
  typedef struct packed {
    logic signed [15:0] probe_temp;
    logic signed [15:0] board_temp;
    logic               advertising;
    logic [2:0]         run_status;
    logic               hidden_key_closed;
    logic [7:0]         battery_level;
    logic               key_pressed;
  } tick_t;

  // configuration register set
  typedef struct packed {
    logic [7:0]         low_battery_limit;
    logic [3:0]         selftest_rounds;
    logic signed [15:0] probe_band_high;
  } cfg_t;

  // pattern state carried from tick to tick
  typedef struct packed {
    logic [4:0] tick_phase;
    logic [3:0] selftest_left;
  } pat_state_t;

endpackage

>>> hw/rtl/slps_cfg_regs.sv
// configuration register file of the status led pattern selector
module slps_cfg_regs import slps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // decode the write, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOW_BATT:   cfg_d.low_battery_limit = cfg_wdata_i[7:0];
        REG_ST_ROUNDS:  cfg_d.selftest_rounds   = cfg_wdata_i[3:0];
        REG_PROBE_BAND: cfg_d.probe_band_high   = $signed(cfg_wdata_i[15:0]);
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_battery_limit <= LOW_BATT_RST;
      cfg_q.selftest_rounds   <= ST_ROUNDS_RST;
      cfg_q.probe_band_high   <= PROBE_BAND_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/slps_select.sv
// priority pattern selection and next pattern state for one tick
module slps_select import slps_pkg::*; (
  input  tick_t      tick_i,
  input  cfg_t       cfg_i,
  input  pat_state_t state_i,
  output act_e       act_o,
  output pat_state_t state_o
);

  logic [4:0] ph;
  logic       low_batt;
  logic       st_active;
  logic       st_off_now;
  logic       probe_in_band;

  assign ph            = state_i.tick_phase;
  assign low_batt      = tick_i.battery_level <= cfg_i.low_battery_limit;
  assign st_active     = (tick_i.run_status == ST_SELFTEST2) && (state_i.selftest_left != 4'd0);
  assign probe_in_band = (tick_i.probe_temp > 16'sd0) &&
                         (tick_i.probe_temp < cfg_i.probe_band_high);

  // fixed priority over the status sources
  always_comb begin
    act_o      = ACT_KEEP;
    st_off_now = 1'b0;
    if (tick_i.key_pressed) begin
      act_o = ACT_KEEP;
    end else if (low_batt) begin
      if (ph[1:0] == 2'd0) act_o = ACT_RED;
      else if (ph[1:0] == 2'd2) act_o = ACT_OFF;
    end else if (tick_i.hidden_key_closed) begin
      act_o = ph[0] ? ACT_OFF : ACT_WHITE;
    end else if (tick_i.run_status == ST_CONNECTED) begin
      act_o = ACT_GREEN;
    end else if (st_active) begin
      if (ph == PH_ST_RED) act_o = ACT_RED;
      else if (ph == PH_ST_GREEN) act_o = ACT_GREEN;
      else if (ph == PH_ST_BLUE) act_o = ACT_BLUE;
      else if (ph == PH_ST_OFF) begin
        act_o      = ACT_OFF;
        st_off_now = 1'b1;
      end
    end else if (tick_i.advertising) begin
      if (ph[1:0] == 2'd0) act_o = ACT_BLUE;
      else if (ph[1:0] == 2'd1) act_o = ACT_OFF;
    end else if (tick_i.run_status == ST_LOGGING) begin
      if (ph == 5'd0) begin
        if (tick_i.board_temp < 16'sd0) act_o = ACT_YELLOW;
        else if (probe_in_band) act_o = ACT_BLUE;
        else act_o = ACT_GREEN;
      end else if (ph == 5'd1) begin
        act_o = ACT_OFF;
      end
    end else if (tick_i.run_status == ST_PROBECAL) begin
      if (ph == 5'd0) act_o = ACT_YELLOW;
      else if (ph == 5'd1) act_o = ACT_OFF;
    end
  end

  // rounds reload outside self-test, phase wraps after its last value
  always_comb begin
    if (tick_i.run_status != ST_SELFTEST2) begin
      state_o.selftest_left = cfg_i.selftest_rounds;
    end else if (st_off_now) begin
      state_o.selftest_left = state_i.selftest_left - 4'd1;
    end else begin
      state_o.selftest_left = state_i.selftest_left;
    end
    state_o.tick_phase = (ph >= PHASE_LAST) ? 5'd0 : ph + 5'd1;
  end

endmodule

>>> hw/rtl/status_led_pattern_selector_top.sv
// top level of the status led pattern selector
// Each request on the slave side is one status tick and yields exactly one led action
// on the master side. The block takes one tick per clock cycle while the master side
// does not stall; a tick is held in an input register, its action is chosen by the
// priority logic and lands in a result register. The tick phase and self-test round
// count advance as a tick moves from the input register to the result register.
// Configuration writes take effect at the next clock edge and are meant to be done
// while no tick is in flight.
module status_led_pattern_selector_top import slps_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // status tick stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // key_pressed[0], battery_level[8:1], hidden_key_closed[9], run_status[12:10],
  // advertising[13], board_temp[29:14], probe_temp[45:30], zero[47:46]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // led action stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // led_action[2:0], zero[7:3]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  cfg_t       cfg;
  tick_t      tick_q;
  logic       in_vld_q;
  logic       out_vld_q;
  act_e       act_q;
  act_e       act_d;
  pat_state_t state_q, state_d;
  logic       s_acc;
  logic       adv;

  slps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  slps_select u_sel (
    .tick_i  (tick_q),
    .cfg_i   (cfg),
    .state_i (state_q),
    .act_o   (act_d),
    .state_o (state_d)
  );

  // handshake: the input stage moves on when the result register frees up
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      tick_q <= tick_t'(s_axis_tdata[45:0]);
    end
  end

  // result register and pattern state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q             <= 1'b0;
      state_q.tick_phase    <= 5'd0;
      state_q.selftest_left <= ST_ROUNDS_RST;
    end else begin
      if (adv) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      act_q <= act_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-3){1'b0}}, act_q};

  // checks
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.tick_phase <= PHASE_LAST)
    else $error("tick phase out of range");

  a_phase_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (state_q.tick_phase == $past(state_q.tick_phase) + 5'd1) ||
            (state_q.tick_phase == 5'd0))
    else $error("tick phase did not advance");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(state_q))
    else $error("pattern state changed without a tick");

  a_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && tick_q.run_status != ST_SELFTEST2 && !cfg_we_i) |=>
      state_q.selftest_left == cfg.selftest_rounds)
    else $error("self-test rounds not reloaded");

  a_no_lost_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |=> out_vld_q)
    else $error("pending result dropped");

endmodule
